// ===== design/pbd_pkg.sv =====
// Package with shared types and constants for the pulse beat detector.
`default_nettype none
package pbd_pkg;
  localparam int unsigned CFG_W = 23;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PERIOD_W = 28;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] REG_MIN_TH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_HOLD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY = 3'd7;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic beat;
    logic [PERIOD_W-1:0] beat_period;
  } out_item_t;
endpackage
`default_nettype wire

// ===== design/pulse_beat_detector.sv =====
// Adaptive-threshold pulse beat detector with an iterative divider for the linear ramp.
// A request is accepted in SQ_IDLE, evaluated in SQ_EVAL and presented from SQ_DONE; when the
// linear ramp runs, the divider comes between: a load step, 37 restoring steps and write-back.
// A new request is taken only after the previous result has left SQ_DONE; a result that
// is not taken holds the next one in the final state. Reset is synchronous, active low:
// registers go to their defaults, detector to init holdoff, threshold to min_threshold.
`default_nettype none
module pulse_beat_detector #(
  parameter int unsigned FALLOFF_GAIN = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pbd_pkg::in_item_t    in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output pbd_pkg::out_item_t        out_data,
  input  wire logic                 cfg_we,
  input  wire logic [2:0]           cfg_index,
  input  wire logic [22:0]          cfg_data
);
  typedef enum logic [4:0] {
    DT_INIT = 5'b00001, DT_WAIT = 5'b00010, DT_FOLLOW = 5'b00100,
    DT_MAYBE = 5'b01000, DT_MASK = 5'b10000
  } det_t;
  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001, SQ_EVAL = 4'b0010, SQ_DIV = 4'b0100, SQ_DONE = 4'b1000
  } seq_t;

  logic [22:0] min_th_r, max_th_r, step_r;
  logic [15:0] init_hold_r, lost_r, mask_hold_r;
  logic [8:0]  alpha_r;
  logic [16:0] decay_r;

  det_t det_r, det_nxt;
  seq_t seq_r;
  logic signed [25:0] th_r, th_nxt;
  logic [27:0] per_r, per_nxt;
  logic signed [23:0] peak_r, peak_nxt;
  logic [31:0] lbt_r, lbt_nxt;
  pbd_pkg::in_item_t item_r;
  logic beat_r;
  logic beat_nxt, need_div;
  // Divider: with FALLOFF_GAIN = 7, numerator below 2^23*7*256 < 2^37.
  logic [36:0] quo_r;
  logic [28:0] rem_r;
  logic [5:0]  cnt_r;
  logic [28:0] rem_sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_th_r <= 23'd5120; max_th_r <= 23'd204800; step_r <= 23'd7680;
      init_hold_r <= 16'd2000; lost_r <= 16'd2000; mask_hold_r <= 16'd200;
      alpha_r <= 9'd154; decay_r <= 17'd64881;
    end else if (cfg_we) begin
      case (cfg_index)
        pbd_pkg::REG_MIN_TH:    min_th_r <= cfg_data;
        pbd_pkg::REG_MAX_TH:    max_th_r <= cfg_data;
        pbd_pkg::REG_STEP:      step_r <= cfg_data;
        pbd_pkg::REG_INIT_HOLD: init_hold_r <= cfg_data[15:0];
        pbd_pkg::REG_LOST:      lost_r <= cfg_data[15:0];
        pbd_pkg::REG_MASK_HOLD: mask_hold_r <= cfg_data[15:0];
        pbd_pkg::REG_ALPHA:     alpha_r <= cfg_data[8:0];
        pbd_pkg::REG_DECAY:     decay_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  logic signed [25:0] s_x, maxth_x, minth_x;
  logic [31:0] since;
  logic [16:0] dec_f;
  logic [8:0]  alpha_c;
  logic signed [25:0] th_mid;
  logic [42:0] dec_prod;
  logic [48:0] acc;
  logic [40:0] acc_sh;
  logic lower;

  assign s_x = 26'(item_r.sample);
  assign maxth_x = 26'(signed'({1'b0, max_th_r}));
  assign minth_x = 26'(signed'({1'b0, min_th_r}));
  assign since = item_r.now_ms - lbt_r;
  assign dec_f = decay_r[16] ? 17'h10000 : decay_r;
  assign alpha_c = alpha_r[8] ? 9'd256 : alpha_r;

  // Evaluate one detector step; a linear ramp hands off to the divider.
  always_comb begin
    det_nxt = det_r; th_mid = th_r; per_nxt = per_r; peak_nxt = peak_r;
    lbt_nxt = lbt_r; beat_nxt = 1'b0; lower = 1'b0;
    acc = 49'(alpha_c) * 49'({since, 8'd0}) + 49'(9'd256 - alpha_c) * 49'(per_r);
    acc_sh = acc[48:8];
    case (det_r)
      DT_WAIT: begin
        if (s_x > th_r) begin
          th_mid = (s_x < maxth_x) ? s_x : maxth_x;
          det_nxt = DT_FOLLOW;
        end
        if (since > 32'(lost_r)) begin
          per_nxt = '0; peak_nxt = '0;
        end
        lower = 1'b1;
      end
      DT_FOLLOW: begin
        if (s_x < th_r) det_nxt = DT_MAYBE;
        else th_mid = (s_x < maxth_x) ? s_x : maxth_x;
      end
      DT_MAYBE: begin
        if (s_x + 26'(signed'({1'b0, step_r})) < th_r) begin
          beat_nxt = 1'b1; peak_nxt = item_r.sample; det_nxt = DT_MASK;
          if (since != 32'd0)
            per_nxt = (acc_sh > 41'(pbd_pkg::PERIOD_MAX)) ? pbd_pkg::PERIOD_MAX
                                                          : acc_sh[27:0];
          lbt_nxt = item_r.now_ms;
        end else det_nxt = DT_FOLLOW;
      end
      DT_MASK: begin
        if (since > 32'(mask_hold_r)) det_nxt = DT_WAIT;
        lower = 1'b1;
      end
      default: if (item_r.now_ms > 32'(init_hold_r)) det_nxt = DT_WAIT;
    endcase
    need_div = lower && (peak_nxt > 24'sd0) && (per_nxt != '0);
    dec_prod = 43'(th_mid[25:0]) * 43'(dec_f);
    th_nxt = th_mid;
    if (lower && !need_div) begin
      th_nxt = 26'(dec_prod[42:16]);
      if (th_nxt < minth_x) th_nxt = minth_x;
    end
  end

  logic [36:0] num;
  assign num = 37'(37'(unsigned'(peak_r)) * 37'(FALLOFF_GAIN)) << 8;
  assign rem_sh = {rem_r[27:0], quo_r[36]};
  // The quotient can far exceed the threshold, so the difference keeps its full width.
  logic signed [38:0] th_ramp;
  assign th_ramp = 39'(th_r) - 39'(signed'({2'b00, quo_r}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= SQ_IDLE; det_r <= DT_INIT; th_r <= 26'sd5120; per_r <= '0;
      peak_r <= '0; lbt_r <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (seq_r)
        SQ_IDLE: if (in_valid && in_ready) begin
          item_r <= in_data; seq_r <= SQ_EVAL;
        end
        SQ_EVAL: begin
          det_r <= det_nxt; th_r <= th_nxt; per_r <= per_nxt;
          peak_r <= peak_nxt; lbt_r <= lbt_nxt;
          beat_r <= beat_nxt;
          seq_r <= need_div ? SQ_DIV : SQ_DONE;
          rem_r <= '0; cnt_r <= '0;
        end
        SQ_DIV: begin
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd0) quo_r <= num;
          else if (cnt_r == 6'd38) begin
            th_r <= (th_ramp < 39'(minth_x)) ? minth_x : th_ramp[25:0];
            seq_r <= SQ_DONE;
          end else begin
            if (rem_sh >= 29'(per_r)) begin
              rem_r <= rem_sh - 29'(per_r); quo_r <= {quo_r[35:0], 1'b1};
            end else begin
              rem_r <= rem_sh; quo_r <= {quo_r[35:0], 1'b0};
            end
          end
        end
        SQ_DONE: if (!out_valid || out_ready) begin
          out_data.beat <= beat_r; out_data.beat_period <= per_r;
          out_valid <= 1'b1; seq_r <= SQ_IDLE;
        end
        default: seq_r <= SQ_IDLE;
      endcase
    end
  end

  assign in_ready = (seq_r == SQ_IDLE);

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_DIV) |-> (cnt_r <= 6'd38))
    else $error("divider overran");
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == SQ_EVAL) |=> !in_ready)
    else $error("accepted during work");
  a_th_floor: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) && $past(det_r == DT_MASK, 2) |-> th_r >= minth_x)
    else $error("threshold below floor");
endmodule
`default_nettype wire

// ===== sim/pbd_checker.sv =====
// Checker for the pulse beat detector: tracks the register writes, predicts each result, compares.
module pbd_checker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  pbd_pkg::in_item_t   in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  pbd_pkg::out_item_t  out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [22:0]         cfg_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned GAIN = 7;

  typedef enum logic [2:0] {
    DS_INIT = 3'd0, DS_WAIT = 3'd1, DS_FOLLOW = 3'd2, DS_MAYBE = 3'd3, DS_MASK = 3'd4
  } det_state_t;

  logic [22:0] r_min_th, r_max_th, r_step;
  logic [15:0] r_init_hold, r_lost, r_mask_hold;
  logic [8:0]  r_alpha;
  logic [16:0] r_decay;

  det_state_t      st;
  longint          thr;
  longint unsigned per_avg;
  longint          peak;
  logic [31:0]     beat_time;

  pbd_pkg::out_item_t beat_queue[$];

  assign pending = beat_queue.size();

  function automatic longint clamp_follow(longint s);
    return (s < longint'(r_max_th)) ? s : longint'(r_max_th);
  endfunction

  task automatic drop_threshold();
    longint unsigned num, f;
    if (peak > 0 && per_avg > 0) begin
      num = (longint'(peak) * GAIN) << 8;
      thr = thr - longint'(num / per_avg);
    end else begin
      f = (r_decay > 17'd65536) ? 64'd65536 : longint'(r_decay);
      thr = longint'((longint'(thr) * f) >> 16);
    end
    if (thr < longint'(r_min_th))
      thr = longint'(r_min_th);
  endtask

  task automatic predict_beat(pbd_pkg::in_item_t it);
    longint s;
    logic [31:0] since;
    longint unsigned a, acc;
    pbd_pkg::out_item_t res;
    s = longint'($signed(it.sample));
    since = it.now_ms - beat_time;
    res.beat = 1'b0;
    case (st)
      DS_WAIT: begin
        if (s > thr) begin
          thr = clamp_follow(s);
          st = DS_FOLLOW;
        end
        if (since > 32'(r_lost)) begin
          per_avg = 0;
          peak = 0;
        end
        drop_threshold();
      end
      DS_FOLLOW: begin
        if (s < thr) st = DS_MAYBE;
        else thr = clamp_follow(s);
      end
      DS_MAYBE: begin
        if (s + longint'(r_step) < thr) begin
          res.beat = 1'b1;
          peak = s;
          st = DS_MASK;
          if (since != 32'd0) begin
            a = (r_alpha > 9'd256) ? 64'd256 : longint'(r_alpha);
            acc = (a * (longint'(since) << 8) + (256 - a) * per_avg) >> 8;
            per_avg = (acc > longint'(pbd_pkg::PERIOD_MAX)) ?
                      longint'(pbd_pkg::PERIOD_MAX) : acc;
          end
          beat_time = it.now_ms;
        end else begin
          st = DS_FOLLOW;
        end
      end
      DS_MASK: begin
        if (since > 32'(r_mask_hold)) st = DS_WAIT;
        drop_threshold();
      end
      default: begin
        if (it.now_ms > 32'(r_init_hold)) st = DS_WAIT;
      end
    endcase
    res.beat_period = per_avg[pbd_pkg::PERIOD_W-1:0];
    beat_queue.push_back(res);
  endtask

  always @(posedge clk) begin
    pbd_pkg::out_item_t exp_item;
    int errs;
    if (!rst_n) begin
      r_min_th <= 23'd5120;
      r_max_th <= 23'd204800;
      r_step <= 23'd7680;
      r_init_hold <= 16'd2000;
      r_lost <= 16'd2000;
      r_mask_hold <= 16'd200;
      r_alpha <= 9'd154;
      r_decay <= 17'd64881;
      st = DS_INIT;
      thr = 5120;
      per_avg = 0;
      peak = 0;
      beat_time = '0;
      beat_queue.delete();
      fail_count <= 0;
    end else begin
      errs = 0;
      if (cfg_we) begin
        case (cfg_index)
          pbd_pkg::REG_MIN_TH:    r_min_th <= cfg_data;
          pbd_pkg::REG_MAX_TH:    r_max_th <= cfg_data;
          pbd_pkg::REG_STEP:      r_step <= cfg_data;
          pbd_pkg::REG_INIT_HOLD: r_init_hold <= cfg_data[15:0];
          pbd_pkg::REG_LOST:      r_lost <= cfg_data[15:0];
          pbd_pkg::REG_MASK_HOLD: r_mask_hold <= cfg_data[15:0];
          pbd_pkg::REG_ALPHA:     r_alpha <= cfg_data[8:0];
          pbd_pkg::REG_DECAY:     r_decay <= cfg_data[16:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_beat(in_data);
      if (out_valid && out_ready) begin
        if (beat_queue.size() == 0) begin
          $error("unexpected result: beat=%0d beat_period=%0d",
                 out_data.beat, out_data.beat_period);
          errs = errs + 1;
        end else begin
          exp_item = beat_queue.pop_front();
          if (out_data.beat !== exp_item.beat) begin
            $error("beat: expected %0d, actual %0d", exp_item.beat, out_data.beat);
            errs = errs + 1;
          end
          if (out_data.beat_period !== exp_item.beat_period) begin
            $error("beat_period: expected %0d, actual %0d",
                   exp_item.beat_period, out_data.beat_period);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

// ===== sim/pulse_beat_detector_tb.sv =====
// Testbench top for the pulse beat detector: stimulus, register phases and verdict.
module pulse_beat_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pbd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pbd_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [22:0] cfg_data = '0;
  int fail_count;
  int pending;
  int cycles = 0;
  bit steady = 1'b0;
  logic [31:0] clock_ms;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  pulse_beat_detector i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pbd_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 17);
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("pulse_beat_detector_tb: FAIL");
      $finish;
    end
  end

  task automatic send_sample(logic [23:0] s, logic [31:0] t);
    while (!steady && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample <= s;
    in_data.now_ms <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Waits until every request has its result, then lets the divider settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [22:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [22:0] mn, logic [22:0] mx, logic [22:0] stp,
                           logic [15:0] ih, logic [15:0] lt, logic [15:0] mh,
                           logic [8:0] al, logic [16:0] dc);
    write_reg(pbd_pkg::REG_MIN_TH, mn);
    write_reg(pbd_pkg::REG_MAX_TH, mx);
    write_reg(pbd_pkg::REG_STEP, stp);
    write_reg(pbd_pkg::REG_INIT_HOLD, 23'(ih));
    write_reg(pbd_pkg::REG_LOST, 23'(lt));
    write_reg(pbd_pkg::REG_MASK_HOLD, 23'(mh));
    write_reg(pbd_pkg::REG_ALPHA, 23'(al));
    write_reg(pbd_pkg::REG_DECAY, 23'(dc));
    @(posedge clk);
  endtask

  function automatic logic [31:0] tick();
    int r;
    r = $urandom_range(99);
    if (r < 3) return 32'd0;
    if (r < 8) return 32'($urandom_range(3000, 300));
    return 32'($urandom_range(60, 5));
  endfunction

  // One pulse shape: a rise, a clear fall, then a quiet stretch; a few are noise instead.
  task automatic send_pulse();
    int amp, rise, quiet;
    if ($urandom_range(99) < 20) begin
      clock_ms = ($urandom_range(3) == 0) ? $urandom : clock_ms + tick();
      send_sample(24'($urandom), clock_ms);
      return;
    end
    amp = ($urandom_range(9) == 0) ? $urandom_range(8388607, 1000000)
                                   : $urandom_range(300000, 2000);
    rise = $urandom_range(5, 1);
    quiet = $urandom_range(6, 0);
    for (int k = 1; k <= rise; k++) begin
      clock_ms = clock_ms + tick();
      send_sample(24'(amp * k / rise), clock_ms);
    end
    for (int k = 0; k < 2; k++) begin
      clock_ms = clock_ms + tick();
      send_sample(24'(-amp / (2 - k)), clock_ms);
    end
    for (int k = 0; k < quiet; k++) begin
      clock_ms = clock_ms + tick();
      send_sample(24'($signed($urandom_range(4000)) - 2000), clock_ms);
    end
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) drain();
      send_pulse();
    end
    drain();
  endtask

  initial begin
    clock_ms = 32'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset values, then field extremes.
    steady = 1'b1;
    send_sample(24'h000000, 32'd0);
    send_sample(24'h7FFFFF, 32'd2000);
    send_sample(24'h7FFFFF, 32'd2001);
    send_sample(24'h7FFFFF, 32'd2010);
    send_sample(24'h800000, 32'd2020);
    send_sample(24'h800000, 32'd2030);
    send_sample(24'h000000, 32'd2040);
    send_sample(24'h000000, 32'd2300);
    send_sample(24'h7FFFFF, 32'd2310);
    send_sample(24'h000100, 32'd2320);
    send_sample(24'h800000, 32'd2330);
    send_sample(24'h800000, 32'd2330);
    send_sample(24'h000000, 32'hFFFFFFFF);
    send_sample(24'h000000, 32'hFFFFFFFF);
    steady = 1'b0;
    drain();

    write_all(23'd5120, 23'd204800, 23'd7680, 16'd10, 16'd2000, 16'd200, 9'd154, 17'd64881);
    clock_ms = 32'd20;
    random_phase(10);
    // All registers at zero, then all at their widest values.
    write_all('0, '0, '0, '0, '0, '0, '0, '0);
    random_phase(6);
    write_all(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
              9'h1FF, 17'h1FFFF);
    clock_ms = 32'hFFFF_0000;
    random_phase(6);
    // Ceiling below floor.
    write_all(23'd60000, 23'd20000, 23'd1000, 16'd0, 16'd1500, 16'd50, 9'd256, 17'd65536);
    random_phase(6);
    steady = 1'b1;
    write_all(23'd3000, 23'd400000, 23'd2000, 16'd0, 16'd1000, 16'd40, 9'd300, 17'd70000);
    random_phase(8);
    steady = 1'b0;
    for (int p = 0; p < 4; p++) begin
      write_all(23'($urandom_range(20000)), 23'($urandom_range(8388607, 100000)),
                23'($urandom_range(20000)), 16'($urandom_range(300)),
                16'($urandom_range(3000, 100)), 16'($urandom_range(300, 10)),
                9'($urandom), 17'($urandom_range(131071, 50000)));
      random_phase(6);
    end

    drain();
    if (fail_count == 0) begin
      $display("pulse_beat_detector_tb: PASS");
    end else begin
      $display("pulse_beat_detector_tb: FAIL");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
design/pbd_pkg.sv
design/pulse_beat_detector.sv
sim/pbd_checker.sv
sim/pulse_beat_detector_tb.sv
